// File: design/pact_pkg.sv
// package for the periodic compare alarm timer
// holds widths, channel count, command and register codes, shared structs
// no dependencies
package pact_pkg;

    localparam int CHANNELS   = 3;
    localparam int COUNT_W    = 16;
    localparam int PRESC_W    = 3;
    localparam int LOG2_W     = 2;
    localparam int CMD_W      = 3;
    localparam int CHAN_W     = 3;
    localparam int FIRED_W    = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 2;

    localparam logic [CHAN_W-1:0] CHAN_LIMIT = CHAN_W'(CHANNELS);

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK    = 3'd0,
        CMD_ARM_NOW = 3'd1,
        CMD_ARM_REF = 3'd2,
        CMD_DISARM  = 3'd3,
        CMD_READ    = 3'd4
    } t_command;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PRESCALE = 2'd0,
        CFG_COUNT_EN = 2'd1,
        CFG_OVF_REP  = 2'd2
    } t_cfg_reg;

    // one input transaction
    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [CHAN_W-1:0]  channel;
        logic [COUNT_W-1:0] delay;
        logic [COUNT_W-1:0] period;
        logic [COUNT_W-1:0] reference;
    } t_item;

    // one result transaction
    typedef struct packed {
        logic               status;
        logic [COUNT_W-1:0] time_res;
        logic [FIRED_W-1:0] fired_mask;
        logic               overflow;
    } t_result;

    // per-channel control from the top level
    typedef struct packed {
        logic               arm;
        logic               disarm;
        logic               advance;
        logic [COUNT_W-1:0] arm_base;
        logic [COUNT_W-1:0] delay;
        logic [COUNT_W-1:0] period;
        logic [COUNT_W-1:0] new_count;
    } t_chan_ctl;

endpackage

// File: design/pact_if.sv
// channel interfaces for the compare alarm timer: items, results, config writes
// depends on pact_pkg
interface pact_in_if;
    import pact_pkg::*;
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   command;
    logic [CHAN_W-1:0]  channel;
    logic [COUNT_W-1:0] delay;
    logic [COUNT_W-1:0] period;
    logic [COUNT_W-1:0] reference;
    modport source (output valid, command, channel, delay, period, reference, input ready);
    modport sink (input valid, command, channel, delay, period, reference, output ready);
endinterface

interface pact_res_if;
    import pact_pkg::*;
    logic               valid;
    logic               ready;
    logic               status;
    logic [COUNT_W-1:0] time_res;
    logic [FIRED_W-1:0] fired_mask;
    logic               overflow;
    modport source (output valid, status, time_res, fired_mask, overflow, input ready);
    modport sink (input valid, status, time_res, fired_mask, overflow, output ready);
endinterface

interface pact_cfg_if;
    import pact_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] wdata;
    modport source (output valid, reg_index, wdata, input ready);
    modport sink (input valid, reg_index, wdata, output ready);
endinterface

// File: design/pact_chan.sv
// one compare channel: compare value, reload period, armed flag
// depends on pact_pkg
module pact_chan (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pact_pkg::t_chan_ctl i_ctl,
    output logic                o_fired
);
    import pact_pkg::*;

    logic [COUNT_W-1:0] r_cmp, n_cmp;
    logic [COUNT_W-1:0] r_period, n_period;
    logic               r_armed, n_armed;
    logic               hit;

    // match only when the counter steps onto the compare value
    assign hit     = i_ctl.advance && r_armed && (r_cmp == i_ctl.new_count);
    assign o_fired = hit;

    // next channel state
    always_comb begin
        n_cmp    = r_cmp;
        n_period = r_period;
        n_armed  = r_armed;
        if (i_ctl.arm) begin
            n_cmp    = i_ctl.arm_base + i_ctl.delay;
            n_period = i_ctl.period;
            n_armed  = 1'b1;
        end else if (i_ctl.disarm) begin
            n_cmp    = '0;
            n_period = '0;
            n_armed  = 1'b0;
        end else if (hit) begin
            if (r_period != '0) begin
                n_cmp = r_cmp + r_period;
            end else begin
                n_cmp   = '0;
                n_armed = 1'b0;
            end
        end
    end

    // armed flag is control, compare and period are payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed <= 1'b0;
        end else begin
            r_armed <= n_armed;
        end
        r_cmp    <= n_cmp;
        r_period <= n_period;
    end

endmodule

// File: design/periodic_compare_alarm_timer.sv
// top level of the periodic compare alarm timer
// depends on pact_pkg, pact_if (pact_in_if, pact_res_if, pact_cfg_if) and pact_chan
//
// A 16-bit counter with a power-of-two prescaler and CHANNELS compare channels.
// Each item is one command (tick, arm from now, arm from reference, disarm,
// read time) and gives exactly one result. An item enters an input register;
// when it moves on, the counter and all channel registers are updated in
// one step while the result is written to an output register; the block takes
// one item per clock cycle while results are not stalled. That single update
// step over the counter and channel state sets the rate. A stalled result only
// blocks new items once both registers are full. Configuration registers are
// always ready and take effect at once.
module periodic_compare_alarm_timer (
    input  logic  i_clk,
    input  logic  i_rst_n,
    pact_in_if.sink    i_in,
    pact_res_if.source o_res,
    pact_cfg_if.sink   i_cfg
);
    import pact_pkg::*;

    // configuration registers
    logic [LOG2_W-1:0] r_presc_log2;
    logic              r_count_en;
    logic              r_ovf_rep;

    // timer state
    logic [COUNT_W-1:0] r_count, n_count;
    logic [PRESC_W-1:0] r_presc, n_presc;

    // pipeline registers
    logic    r_s1_valid;
    t_item   r_s1;
    logic    r_out_valid;
    t_result r_out, n_out;

    logic               s1_move;
    logic               in_take;
    logic               is_tick;
    logic               is_chan_cmd;
    logic               bad_chan;
    logic               advance;
    logic [PRESC_W-1:0] limit;
    logic [COUNT_W-1:0] count_inc;
    logic [CHANNELS-1:0] fired;
    logic [FIRED_W-1:0]  fired_mask;
    t_chan_ctl           chan_ctl [CHANNELS];

    // handshake
    assign s1_move    = r_s1_valid && (!r_out_valid || o_res.ready);
    assign i_in.ready = !r_s1_valid || s1_move;
    assign in_take    = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_presc_log2 <= '0;
            r_count_en   <= 1'b0;
            r_ovf_rep    <= 1'b0;
        end else if (i_cfg.valid) begin
            case (i_cfg.reg_index)
                CFG_PRESCALE: r_presc_log2 <= i_cfg.wdata[LOG2_W-1:0];
                CFG_COUNT_EN: r_count_en   <= i_cfg.wdata[0];
                CFG_OVF_REP:  r_ovf_rep    <= i_cfg.wdata[0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
        if (in_take) begin
            r_s1.command   <= i_in.command;
            r_s1.channel   <= i_in.channel;
            r_s1.delay     <= i_in.delay;
            r_s1.period    <= i_in.period;
            r_s1.reference <= i_in.reference;
        end
    end

    // command decode and counter step
    assign is_tick     = (r_s1.command == CMD_TICK);
    assign is_chan_cmd = r_s1.command inside {CMD_ARM_NOW, CMD_ARM_REF, CMD_DISARM};
    assign bad_chan    = is_chan_cmd && (r_s1.channel >= CHAN_LIMIT);
    assign limit       = PRESC_W'((4'd1 << r_presc_log2) - 4'd1);
    assign advance     = s1_move && is_tick && r_count_en && (r_presc >= limit);
    assign count_inc   = r_count + COUNT_W'(1);

    always_comb begin
        n_count = r_count;
        n_presc = r_presc;
        if (s1_move && is_tick && r_count_en) begin
            if (r_presc >= limit) begin
                n_presc = '0;
                n_count = count_inc;
            end else begin
                n_presc = r_presc + PRESC_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_presc <= '0;
        end else begin
            r_count <= n_count;
            r_presc <= n_presc;
        end
    end

    // compare channels
    for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
        always_comb begin
            chan_ctl[c].arm       = s1_move && !bad_chan
                                    && (r_s1.channel == CHAN_W'(c))
                                    && (r_s1.command == CMD_ARM_NOW
                                        || r_s1.command == CMD_ARM_REF);
            chan_ctl[c].disarm    = s1_move && !bad_chan
                                    && (r_s1.channel == CHAN_W'(c))
                                    && (r_s1.command == CMD_DISARM);
            chan_ctl[c].advance   = advance;
            chan_ctl[c].arm_base  = (r_s1.command == CMD_ARM_REF) ? r_s1.reference : r_count;
            chan_ctl[c].delay     = r_s1.delay;
            chan_ctl[c].period    = r_s1.period;
            chan_ctl[c].new_count = count_inc;
        end

        pact_chan u_chan (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (chan_ctl[c]),
            .o_fired (fired[c])
        );
    end

    // each channel drives its own mask bit; mask bits above the channel count read as zero
    for (genvar b = 0; b < FIRED_W; b++) begin : g_mask
        if (b < CHANNELS) begin : g_used
            assign fired_mask[b] = fired[b];
        end else begin : g_unused
            assign fired_mask[b] = 1'b0;
        end
    end

    // result
    always_comb begin
        n_out.status     = bad_chan;
        n_out.time_res   = n_count;
        n_out.fired_mask = fired_mask;
        n_out.overflow   = advance && r_ovf_rep && (count_inc == '0);
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
        if (s1_move) begin
            r_out <= n_out;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.status     = r_out.status;
    assign o_res.time_res   = r_out.time_res;
    assign o_res.fired_mask = r_out.fired_mask;
    assign o_res.overflow   = r_out.overflow;

`ifndef SYNTHESIS
    // input side stalls only when both stages hold a transaction and the output waits
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (r_s1_valid && r_out_valid && !o_res.ready))
        else $error("input stalled while a stage is free");

    // overflow is reported only on a wrap to zero
    a_ovf_at_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.overflow) |-> (r_out.time_res == '0))
        else $error("overflow reported with nonzero time");

    // counter holds unless a tick advances it
    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_count))
        else $error("counter changed without an advancing tick");

    // a rejected channel index comes only from arm or disarm commands
    a_status_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_move && bad_chan) |-> !is_tick)
        else $error("invalid channel status on a tick");
`endif

endmodule

// File: bench/periodic_compare_alarm_timer_tb.sv
// self-checking testbench for periodic_compare_alarm_timer
// depends on pact_pkg, pact_if (pact_in_if, pact_res_if, pact_cfg_if) and the design
// directed script followed by random command mixes under varied register settings
module periodic_compare_alarm_timer_tb;
    import pact_pkg::*;

    localparam logic [CMD_W-1:0] CMD_RSVD_LO = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RSVD_HI = 3'd7;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int END_PAUSE      = 4;
    localparam int RAND_PHASES    = 12;
    localparam int PHASE_ITEMS    = 136;

    // one step of the directed script
    typedef struct {
        bit                    is_write;
        t_cfg_reg              reg_sel;
        logic [CFG_DATA_W-1:0] reg_val;
        t_item                 it;
        bit                    typed;
        t_result               want;
    } t_script_row;

    logic i_clk;
    logic i_rst_n;

    pact_in_if  in_if();
    pact_res_if res_if();
    pact_cfg_if cfg_if();

    periodic_compare_alarm_timer DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    // timer image kept in step with accepted transactions
    logic [LOG2_W-1:0]  cfg_presc_log2;
    logic               cfg_run;
    logic               cfg_ovf_rep;
    logic [COUNT_W-1:0] tmr_count;
    logic [PRESC_W-1:0] tmr_presc;
    logic [COUNT_W-1:0] cmp_value [CHANNELS];
    logic               ch_armed  [CHANNELS];
    logic [COUNT_W-1:0] reload_per [CHANNELS];

    t_result pending_results[$];
    t_script_row script[$];

    bit      typed_pending;
    t_result typed_res;
    bit      settle_needed;
    bit      gaps_on;
    bit      stalls_on;
    int      stall_left;
    int      idle_cycles;
    int      bad_results;
    int      n_items;
    int      n_writes;
    int      n_results;
    int      n_fired;
    int      n_ovf;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // expected result of one command, updating the timer image
    function automatic t_result next_timer_result(input t_item it);
        t_result r;
        logic [PRESC_W-1:0] limit;
        int c;
        r = '0;
        case (it.command)
            CMD_TICK: begin
                if (cfg_run) begin
                    limit = PRESC_W'((1 << cfg_presc_log2) - 1);
                    if (tmr_presc >= limit) begin
                        tmr_presc = '0;
                        tmr_count = tmr_count + 1'b1;
                        r.overflow = (tmr_count == '0) && cfg_ovf_rep;
                        for (c = 0; c < CHANNELS; c++) begin
                            if (ch_armed[c] && cmp_value[c] == tmr_count) begin
                                if (reload_per[c] != '0) begin
                                    cmp_value[c] = cmp_value[c] + reload_per[c];
                                end else begin
                                    cmp_value[c] = '0;
                                    ch_armed[c]  = 1'b0;
                                end
                                r.fired_mask[c] = 1'b1;
                            end
                        end
                    end else begin
                        tmr_presc = tmr_presc + 1'b1;
                    end
                end
            end
            CMD_ARM_NOW, CMD_ARM_REF, CMD_DISARM: begin
                if (it.channel >= CHANNELS) begin
                    r.status = 1'b1;
                end else if (it.command == CMD_DISARM) begin
                    cmp_value[it.channel]  = '0;
                    ch_armed[it.channel]   = 1'b0;
                    reload_per[it.channel] = '0;
                end else begin
                    cmp_value[it.channel] = it.delay +
                        ((it.command == CMD_ARM_NOW) ? tmr_count : it.reference);
                    ch_armed[it.channel]   = 1'b1;
                    reload_per[it.channel] = it.period;
                end
            end
            default: ;
        endcase
        r.time_res = tmr_count;
        return r;
    endfunction

    task automatic flag_bad(input string what, input t_result want, input t_result got);
        bad_results++;
        if (bad_results <= 10) begin
            $display("%0t %s: expected status=%0d time=%h mask=%b ovf=%0d,",
                     $time, what, want.status, want.time_res, want.fired_mask,
                     want.overflow);
            $display("    got status=%0d time=%h mask=%b ovf=%0d",
                     got.status, got.time_res, got.fired_mask, got.overflow);
        end
    endtask

    // monitor: config writes, accepted items, accepted results, watchdog count
    always @(posedge i_clk) begin
        t_item   it;
        t_result want;
        t_result got;
        bit      moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (cfg_if.valid && cfg_if.ready) begin
                moved = 1'b1;
                n_writes++;
                case (cfg_if.reg_index)
                    CFG_PRESCALE: cfg_presc_log2 = cfg_if.wdata[LOG2_W-1:0];
                    CFG_COUNT_EN: cfg_run = cfg_if.wdata[0];
                    CFG_OVF_REP:  cfg_ovf_rep = cfg_if.wdata[0];
                    default: ;
                endcase
            end
            if (in_if.valid && in_if.ready) begin
                moved = 1'b1;
                it = '{in_if.command, in_if.channel, in_if.delay, in_if.period, in_if.reference};
                want = next_timer_result(it);
                if (typed_pending) begin
                    want = typed_res;
                end
                pending_results.push_back(want);
            end
            if (res_if.valid && res_if.ready) begin
                moved = 1'b1;
                n_results++;
                got = '{res_if.status, res_if.time_res, res_if.fired_mask, res_if.overflow};
                if (got.fired_mask != '0) n_fired++;
                if (got.overflow) n_ovf++;
                if (pending_results.size() == 0) begin
                    flag_bad("result with nothing pending", '0, got);
                end else begin
                    want = pending_results.pop_front();
                    if (got.status !== want.status || got.time_res !== want.time_res ||
                        got.fired_mask !== want.fired_mask || got.overflow !== want.overflow) begin
                        flag_bad("result mismatch", want, got);
                    end
                end
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
        end
    end

    // watchdog on cycles without any transaction
    initial begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("simulation failed");
        $finish;
    end

    // gap length: mostly short, a few long
    function automatic int gap_len();
        if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int pick_gap();
        if (!gaps_on || $urandom_range(0, 99) < 70) return 0;
        return gap_len();
    endfunction

    // result side back-pressure
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            res_if.ready <= 1'b0;
            stall_left--;
        end else if (stalls_on && $urandom_range(0, 99) < 25) begin
            res_if.ready <= 1'b0;
            stall_left = gap_len() - 1;
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    // wait until every accepted item has produced its result
    task automatic drain();
        in_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
        settle_needed = 1'b0;
    endtask

    task automatic write_reg(input t_cfg_reg sel, input logic [CFG_DATA_W-1:0] val);
        if (settle_needed) drain();
        cfg_if.valid     <= 1'b1;
        cfg_if.reg_index <= sel;
        cfg_if.wdata     <= val;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_item(input t_item it, input bit typed, input t_result want,
                             input int gap);
        cfg_if.valid <= 1'b0;
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.command   <= it.command;
        in_if.channel   <= it.channel;
        in_if.delay     <= it.delay;
        in_if.period    <= it.period;
        in_if.reference <= it.reference;
        typed_pending = typed;
        typed_res     = want;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        @(negedge i_clk);
        settle_needed = 1'b1;
        n_items++;
    endtask

    function automatic t_script_row op_row(input logic [CMD_W-1:0] cmd,
                                           input logic [CHAN_W-1:0] ch,
                                           input logic [COUNT_W-1:0] dly,
                                           input logic [COUNT_W-1:0] per,
                                           input logic [COUNT_W-1:0] refv);
        t_script_row row;
        row.is_write = 1'b0;
        row.reg_sel  = CFG_PRESCALE;
        row.reg_val  = '0;
        row.it       = '{cmd, ch, dly, per, refv};
        row.typed    = 1'b0;
        row.want     = '0;
        return row;
    endfunction

    function automatic t_script_row chk_row(input logic [CMD_W-1:0] cmd,
                                            input logic [CHAN_W-1:0] ch,
                                            input logic [COUNT_W-1:0] dly,
                                            input logic [COUNT_W-1:0] per,
                                            input logic [COUNT_W-1:0] refv,
                                            input logic st, input logic [COUNT_W-1:0] tm,
                                            input logic [FIRED_W-1:0] mask, input logic ovf);
        t_script_row row;
        row = op_row(cmd, ch, dly, per, refv);
        row.typed = 1'b1;
        row.want  = '{st, tm, mask, ovf};
        return row;
    endfunction

    function automatic t_script_row reg_row(input t_cfg_reg sel,
                                            input logic [CFG_DATA_W-1:0] val);
        t_script_row row;
        row.is_write = 1'b1;
        row.reg_sel  = sel;
        row.reg_val  = val;
        row.it       = '0;
        row.typed    = 1'b0;
        row.want     = '0;
        return row;
    endfunction

    // random command mix, biased toward ticks and short delays so channels fire
    function automatic t_item random_command_item();
        t_item it;
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)      it.command = CMD_TICK;
        else if (r < 70) it.command = CMD_ARM_NOW;
        else if (r < 80) it.command = CMD_ARM_REF;
        else if (r < 87) it.command = CMD_DISARM;
        else if (r < 95) it.command = CMD_READ;
        else             it.command = CMD_W'($urandom_range(CMD_RSVD_LO, CMD_RSVD_HI));
        it.channel = ($urandom_range(0, 99) < 85) ? CHAN_W'($urandom_range(0, CHANNELS - 1))
                                                  : CHAN_W'($urandom_range(0, 7));
        it.delay = ($urandom_range(0, 99) < 80) ? COUNT_W'($urandom_range(0, 24))
                                                : COUNT_W'($urandom);
        r = $urandom_range(0, 99);
        if (r < 30)      it.period = '0;
        else if (r < 80) it.period = COUNT_W'($urandom_range(1, 16));
        else             it.period = COUNT_W'($urandom);
        if ($urandom_range(0, 99) < 70) begin
            it.reference = tmr_count + COUNT_W'($urandom_range(0, 8)) - COUNT_W'(4);
        end else begin
            it.reference = COUNT_W'($urandom);
        end
        return it;
    endfunction

    initial begin
        t_result no_res;
        int ph;
        int k;
        logic [LOG2_W-1:0] p_log2;
        logic p_run;
        logic p_rep;

        // known values on every input from time zero
        i_rst_n          = 1'b0;
        in_if.valid      = 1'b0;
        in_if.command    = CMD_TICK;
        in_if.channel    = '0;
        in_if.delay      = '0;
        in_if.period     = '0;
        in_if.reference  = '0;
        res_if.ready     = 1'b0;
        cfg_if.valid     = 1'b0;
        cfg_if.reg_index = CFG_PRESCALE;
        cfg_if.wdata     = '0;
        cfg_presc_log2   = '0;
        cfg_run          = 1'b0;
        cfg_ovf_rep      = 1'b0;
        tmr_count        = '0;
        tmr_presc        = '0;
        for (k = 0; k < CHANNELS; k++) begin
            cmp_value[k]  = '0;
            ch_armed[k]   = 1'b0;
            reload_per[k] = '0;
        end
        typed_pending = 1'b0;
        typed_res     = '0;
        settle_needed = 1'b0;
        gaps_on       = 1'b0;
        stalls_on     = 1'b0;
        stall_left    = 0;
        idle_cycles   = 0;
        bad_results   = 0;
        n_items       = 0;
        n_writes      = 0;
        n_results     = 0;
        n_fired       = 0;
        n_ovf         = 0;
        no_res        = '0;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed script: reset state, stopped counter, bad channels, reserved codes
        script.push_back(chk_row(CMD_READ, 0, 0, 0, 0, 0, 0, 3'b000, 0));
        script.push_back(chk_row(CMD_TICK, 0, 0, 0, 0, 0, 0, 3'b000, 0));
        script.push_back(chk_row(CMD_ARM_NOW, 3, 5, 5, 0, 1, 0, 3'b000, 0));
        script.push_back(chk_row(CMD_ARM_REF, 7, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                 1, 0, 3'b000, 0));
        script.push_back(chk_row(CMD_DISARM, 4, 0, 0, 0, 1, 0, 3'b000, 0));
        script.push_back(chk_row(CMD_RSVD_LO, 0, 0, 0, 0, 0, 0, 3'b000, 0));
        script.push_back(chk_row(CMD_RSVD_HI, 7, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                 0, 0, 3'b000, 0));
        // run at full rate with overflow reporting
        script.push_back(reg_row(CFG_PRESCALE, 2'd0));
        script.push_back(reg_row(CFG_COUNT_EN, 2'd1));
        script.push_back(reg_row(CFG_OVF_REP, 2'd1));
        // one-shot, periodic from a wrapped reference, zero delay from now
        script.push_back(chk_row(CMD_ARM_NOW, 0, 1, 0, 0, 0, 0, 3'b000, 0));
        script.push_back(chk_row(CMD_ARM_REF, 1, 3, 16'hFFFF, 16'hFFFF, 0, 0, 3'b000, 0));
        script.push_back(chk_row(CMD_ARM_NOW, 2, 0, 0, 0, 0, 0, 3'b000, 0));
        script.push_back(chk_row(CMD_TICK, 0, 0, 0, 0, 0, 1, 3'b001, 0));
        script.push_back(chk_row(CMD_TICK, 0, 0, 0, 0, 0, 2, 3'b010, 0));
        script.push_back(chk_row(CMD_READ, 7, 0, 0, 0, 0, 2, 3'b000, 0));
        script.push_back(chk_row(CMD_DISARM, 2, 0, 0, 0, 0, 2, 3'b000, 0));
        script.push_back(chk_row(CMD_ARM_NOW, 2, 16'hFFFF, 1, 0, 0, 2, 3'b000, 0));
        // prescaler lowered while its count sits above the new limit
        script.push_back(reg_row(CFG_PRESCALE, 2'd3));
        script.push_back(op_row(CMD_TICK, 0, 0, 0, 0));
        script.push_back(op_row(CMD_TICK, 0, 0, 0, 0));
        script.push_back(op_row(CMD_TICK, 0, 0, 0, 0));
        script.push_back(op_row(CMD_TICK, 0, 0, 0, 0));
        script.push_back(reg_row(CFG_PRESCALE, 2'd1));
        script.push_back(op_row(CMD_TICK, 0, 0, 0, 0));
        script.push_back(op_row(CMD_TICK, 0, 0, 0, 0));
        script.push_back(op_row(CMD_TICK, 0, 0, 0, 0));
        // stopped counter after it has moved
        script.push_back(reg_row(CFG_COUNT_EN, 2'd0));
        script.push_back(op_row(CMD_TICK, 0, 0, 0, 0));
        script.push_back(op_row(CMD_ARM_REF, 0, 0, 0, 0));

        foreach (script[i]) begin
            if (script[i].is_write) begin
                write_reg(script[i].reg_sel, script[i].reg_val);
            end else begin
                send_item(script[i].it, script[i].typed, script[i].want, pick_gap());
            end
        end

        // random phases, each under its own register setting
        for (ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph)
                0: begin p_log2 = 2'd0; p_run = 1'b1; p_rep = 1'b1; end
                1: begin p_log2 = 2'd3; p_run = 1'b1; p_rep = 1'b0; end
                2: begin p_log2 = 2'd1; p_run = 1'b0; p_rep = 1'b1; end
                3: begin p_log2 = 2'd2; p_run = 1'b1; p_rep = 1'b0; end
                default: begin
                    p_log2 = LOG2_W'($urandom_range(0, 3));
                    p_run  = ($urandom_range(0, 99) < 85);
                    p_rep  = 1'($urandom_range(0, 1));
                end
            endcase
            write_reg(CFG_PRESCALE, p_log2);
            write_reg(CFG_COUNT_EN, {1'($urandom_range(0, 1)), p_run});
            write_reg(CFG_OVF_REP, {1'($urandom_range(0, 1)), p_rep});
            gaps_on   = (ph != 0) && ($urandom_range(0, 2) != 0);
            stalls_on = (ph != 0) && ($urandom_range(0, 2) != 0);
            for (k = 0; k < PHASE_ITEMS; k++) begin
                send_item(random_command_item(), 1'b0, no_res, pick_gap());
            end
        end

        // let everything drain
        cfg_if.valid <= 1'b0;
        drain();
        repeat (END_PAUSE) @(posedge i_clk);

        $display("covered %0d items and %0d register writes", n_items, n_writes);
        $display("%0d results checked, %0d with a channel firing, %0d with overflow,",
                 n_results, n_fired, n_ovf);
        $display("%0d mismatches", bad_results);
        if (bad_results == 0 && pending_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
